/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the log-mel front end RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, off while rst is high
`define LMSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check, active through reset as well
`define LMSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/lmsf_pkg.sv */
// Shared constants, codes and command/status types of the log-mel front end
`timescale 1ns / 1ps
package lmsf_pkg;

  localparam int MAX_FFT_DEF     = 512;
  localparam int MAX_MELS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_W     = 16;
  localparam int CMD_W      = 3;
  localparam int TIDX_W     = 15;
  localparam int LOG_W      = 14;
  localparam int MIDX_W     = 6;
  localparam int FRAME_W    = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_W      = 10;
  localparam int MELREG_W   = 7;
  localparam int POW_W      = 64;

  localparam logic [CMD_W-1:0] CMD_WINDOW = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COSINE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SINE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FILTER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FFT_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEL_COUNT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLES = 8'd3;

  localparam logic [LEN_W-1:0]      RST_FFT_LENGTH  = 10'd400;
  localparam logic [LEN_W-1:0]      RST_HOP_SIZE    = 10'd160;
  localparam logic [MELREG_W-1:0]   RST_MEL_COUNT   = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_MAX_SAMPLES = 32'd0;

  // ln(2) in Q16, and ln(1e-10) in Q6.8
  localparam logic signed [17:0]      LN2_Q16   = 18'sd45426;
  localparam logic signed [LOG_W-1:0] LOG_FLOOR = -14'sd5895;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_WIN    = 13'b0000000000010,
    ST_WDRAIN = 13'b0000000000100,
    ST_DFT    = 13'b0000000001000,
    ST_DDRAIN = 13'b0000000010000,
    ST_SQRE   = 13'b0000000100000,
    ST_SQIM   = 13'b0000001000000,
    ST_PWR    = 13'b0000010000000,
    ST_MEL    = 13'b0000100000000,
    ST_MDRAIN = 13'b0001000000000,
    ST_NORM   = 13'b0010000000000,
    ST_LMUL   = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic take;
    logic win_issue;
    logic dft_begin;
    logic dft_issue;
    logic sq_re;
    logic sq_im;
    logic pwr_write;
    logic mel_begin;
    logic mel_issue;
    logic log_start;
    logic log_step;
    logic log_mul;
    logic out_load;
    logic mel_next;
    logic frame_done;
  } dp_cmd_t;

  typedef struct packed {
    logic trigger;
    logic last_i;
    logic last_k;
    logic last_m;
    logic pipe_busy;
    logic log_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/lmsf_if.sv */
// Channel interfaces: input beats, result beats and configuration writes
`timescale 1ns / 1ps
interface lmsf_in_if import lmsf_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic [TIDX_W-1:0]             table_index;
  logic signed [COEF_W-1:0]      coef_value;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  modport source (output valid, cmd, table_index, coef_value, sample_value, input ready);
  modport sink (input valid, cmd, table_index, coef_value, sample_value, output ready);
endinterface

interface lmsf_out_if import lmsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LOG_W-1:0]  mel_log;
  logic [MIDX_W-1:0]        mel_index;
  logic [FRAME_W-1:0]       frame_number;
  logic                     frame_last;
  modport source (output valid, mel_log, mel_index, frame_number, frame_last, input ready);
  modport sink (input valid, mel_log, mel_index, frame_number, frame_last, output ready);
endinterface

interface lmsf_cfg_if import lmsf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/log_mel_spectrogram_frontend_core.sv */
// Log-mel front end: top level joining the sequencer and the datapath
// Table and sample beats are taken while the sequencer is idle. A sample that
// completes a frame holds off input until that frame's last mel result is loaded;
// the direct DFT runs on a single complex MAC. The first result leaves after the
// window pass, the DFT and power of every bin, and the first mel sum and its log.
// rst is synchronous: counters, config and handshake state reset; tables are
// undefined until written, and the sample ring needs no clearing pass.
`timescale 1ns / 1ps
module log_mel_spectrogram_frontend_core import lmsf_pkg::*; #(
  parameter int MAX_FFT     = MAX_FFT_DEF,
  parameter int MAX_MELS    = MAX_MELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lmsf_in_if.sink     feed,
  lmsf_out_if.source  result,
  lmsf_cfg_if.sink    cfg
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config writes are always taken; the host writes only while idle
  assign cfg.ready = 1'b1;

  lmsf_ctrl u_ctrl (
    .clk,
    .rst,
    .feed_valid (feed.valid),
    .feed_ready (feed.ready),
    .stat,
    .cmd
  );

  // datapath holds all storage: ring, tables, x buffer, power store, result beat
  lmsf_dp #(
    .MAX_FFT     (MAX_FFT),
    .MAX_MELS    (MAX_MELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk,
    .rst,
    .feed_cmd    (feed.cmd),
    .feed_index  (feed.table_index),
    .feed_coef   (feed.coef_value),
    .feed_sample (feed.sample_value),
    .cfg_write   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .res_ready   (result.ready),
    .res_valid   (result.valid),
    .res_log     (result.mel_log),
    .res_mel     (result.mel_index),
    .res_frame   (result.frame_number),
    .res_last    (result.frame_last),
    .cmd,
    .stat
  );

endmodule

/* hw/rtl/lmsf_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lmsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lmsf_ctrl.sv */
// Frame sequencer: steps the datapath through window, DFT, power, mel and log
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lmsf_ctrl import lmsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     feed_valid,
  output logic     feed_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    cmd        = '0;
    st_next    = st;
    feed_ready = 1'b0;
    case (st)
      ST_IDLE: begin
        feed_ready = 1'b1;
        cmd.take   = feed_valid;
        if (feed_valid && stat.trigger) begin
          st_next = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.win_issue = 1'b1;
        if (stat.last_i) begin
          st_next = ST_WDRAIN;
        end
      end
      ST_WDRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.dft_begin = 1'b1;
          st_next       = ST_DFT;
        end
      end
      ST_DFT: begin
        cmd.dft_issue = 1'b1;
        if (stat.last_i) begin
          st_next = ST_DDRAIN;
        end
      end
      ST_DDRAIN: begin
        if (!stat.pipe_busy) begin
          st_next = ST_SQRE;
        end
      end
      ST_SQRE: begin
        cmd.sq_re = 1'b1;
        st_next   = ST_SQIM;
      end
      ST_SQIM: begin
        cmd.sq_im = 1'b1;
        st_next   = ST_PWR;
      end
      ST_PWR: begin
        cmd.pwr_write = 1'b1;
        if (stat.last_k) begin
          cmd.mel_begin = 1'b1;
          st_next       = ST_MEL;
        end else begin
          cmd.dft_begin = 1'b1;
          st_next       = ST_DFT;
        end
      end
      ST_MEL: begin
        cmd.mel_issue = 1'b1;
        if (stat.last_k) begin
          st_next = ST_MDRAIN;
        end
      end
      ST_MDRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.log_start = 1'b1;
          st_next       = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.log_done) begin
          st_next = ST_LMUL;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_LMUL: begin
        cmd.log_mul = 1'b1;
        st_next     = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.last_m) begin
            cmd.frame_done = 1'b1;
            st_next        = ST_IDLE;
          end else begin
            cmd.mel_next  = 1'b1;
            cmd.mel_begin = 1'b1;
            st_next       = ST_MEL;
          end
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  `LMSF_ASSERT(a_one_issue, $onehot0({cmd.take, cmd.win_issue, cmd.dft_issue, cmd.mel_issue}), "more than one issue strobe")
  `LMSF_ASSERT(a_frame_starts, (cmd.take && stat.trigger) |=> cmd.win_issue, "frame did not start window pass")
  `LMSF_ASSERT(a_log_after_drain, cmd.log_start |-> !stat.pipe_busy, "log read mel sum before pipeline drained")

endmodule

/* hw/rtl/lmsf_dp.sv */
// Datapath: tables, sample ring, MAC pipeline, power store, log unit and result register
`timescale 1ns / 1ps
module lmsf_dp import lmsf_pkg::*; #(
  parameter int MAX_FFT     = MAX_FFT_DEF,
  parameter int MAX_MELS    = MAX_MELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CMD_W-1:0]              feed_cmd,
  input  logic [TIDX_W-1:0]             feed_index,
  input  logic signed [COEF_W-1:0]      feed_coef,
  input  logic signed [SAMPLE_BITS-1:0] feed_sample,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic signed [LOG_W-1:0]       res_log,
  output logic [MIDX_W-1:0]             res_mel,
  output logic [FRAME_W-1:0]            res_frame,
  output logic                          res_last,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat
);

  localparam int STRIDE = MAX_FFT / 2 + 1;
  localparam int FDEPTH = MAX_MELS * STRIDE;
  localparam int AW     = $clog2(MAX_FFT);
  localparam int NW     = $clog2(MAX_FFT + 1);
  localparam int KW     = $clog2(STRIDE);
  localparam int BCW    = $clog2(STRIDE + 1);
  localparam int MW     = $clog2(MAX_MELS);
  localparam int MCW    = $clog2(MAX_MELS + 1);
  localparam int FW     = $clog2(FDEPTH);
  localparam int XW     = SAMPLE_BITS + 1;
  localparam int PW     = XW + COEF_W;
  localparam int TW     = XW + 1;
  localparam int ACW    = TW + AW + 1;
  localparam int WGT_W  = COEF_W - 1;
  localparam int MPW    = POW_W + WGT_W;
  localparam logic [2:0] LOG_STEPS = 3'd6;

  // configuration registers
  logic [LEN_W-1:0]      fft_len, hop_len;
  logic [MELREG_W-1:0]   mels_reg;
  logic [CFG_DATA_W-1:0] max_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      fft_len     <= RST_FFT_LENGTH;
      hop_len     <= RST_HOP_SIZE;
      mels_reg    <= RST_MEL_COUNT;
      max_samples <= RST_MAX_SAMPLES;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FFT_LENGTH:  fft_len     <= cfg_data[LEN_W-1:0];
        REG_HOP_SIZE:    hop_len     <= cfg_data[LEN_W-1:0];
        REG_MEL_COUNT:   mels_reg    <= cfg_data[MELREG_W-1:0];
        REG_MAX_SAMPLES: max_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NW-1:0]    n_eff;
  logic [LEN_W-1:0] hop_eff;
  logic [MCW-1:0]   mels_eff;

  always_comb begin
    if (fft_len == '0) begin
      n_eff = NW'(1);
    end else if (32'(fft_len) > 32'(MAX_FFT)) begin
      n_eff = NW'(MAX_FFT);
    end else begin
      n_eff = NW'(fft_len);
    end
    hop_eff = (hop_len == '0) ? LEN_W'(1) : hop_len;
    if (mels_reg == '0) begin
      mels_eff = MCW'(1);
    end else if (32'(mels_reg) > 32'(MAX_MELS)) begin
      mels_eff = MCW'(MAX_MELS);
    end else begin
      mels_eff = MCW'(mels_reg);
    end
  end

  // sample bookkeeping
  logic [31:0]      seen, seen_inc;
  logic [LEN_W-1:0] hop_cnt, hc_inc, hc_new;
  logic [AW-1:0]    ring_pos, pos_inc, start;
  logic [FRAME_W-1:0] frame_cnt;
  logic sample_ok, samp_take, trig_c;
  logic [NW:0] st_sum;

  assign sample_ok = (feed_cmd == CMD_SAMPLE) &&
                     !((max_samples != '0) && (seen >= max_samples));
  assign samp_take = cmd.take && sample_ok;
  assign seen_inc  = (seen == 32'hFFFF_FFFF) ? seen : seen + 32'd1;
  assign hc_inc    = hop_cnt + LEN_W'(1);
  assign pos_inc   = (ring_pos == AW'(MAX_FFT - 1)) ? '0 : ring_pos + AW'(1);

  always_comb begin
    trig_c = 1'b0;
    hc_new = hop_cnt;
    if (seen_inc < 32'(n_eff)) begin
      trig_c = 1'b0;
    end else if (seen_inc == 32'(n_eff)) begin
      trig_c = 1'b1;
      hc_new = '0;
    end else if (hc_inc >= hop_eff) begin
      trig_c = 1'b1;
      hc_new = '0;
    end else begin
      hc_new = hc_inc;
    end
    if ((NW + 1)'(pos_inc) >= (NW + 1)'(n_eff)) begin
      st_sum = (NW + 1)'(pos_inc) - (NW + 1)'(n_eff);
    end else begin
      st_sum = (NW + 1)'(pos_inc) + (NW + 1)'(MAX_FFT) - (NW + 1)'(n_eff);
    end
    start = AW'(st_sum);
  end

  assign stat.trigger = sample_ok && trig_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      hop_cnt   <= '0;
      ring_pos  <= '0;
      frame_cnt <= '0;
    end else begin
      if (samp_take) begin
        seen     <= seen_inc;
        hop_cnt  <= hc_new;
        ring_pos <= pos_inc;
      end
      if (cmd.frame_done) begin
        frame_cnt <= frame_cnt + FRAME_W'(1);
      end
    end
  end

  // per-frame loop counters and addresses
  logic [NW-1:0]  nf;
  logic [BCW-1:0] nbins;
  logic [MCW-1:0] mf;
  logic [AW-1:0]  i, rp, t;
  logic [KW-1:0]  k;
  logic [MW-1:0]  m;
  logic [FW-1:0]  fbase, fidx;
  logic [NW:0]    t_sum;

  assign t_sum = (NW + 1)'(t) + (NW + 1)'(k);
  assign fidx  = fbase + FW'(k);

  always_ff @(posedge clk) begin
    if (samp_take && trig_c) begin
      nf    <= n_eff;
      nbins <= BCW'(n_eff >> 1) + BCW'(1);
      mf    <= mels_eff;
      rp    <= start;
      i     <= '0;
      k     <= '0;
      m     <= '0;
      fbase <= '0;
    end else begin
      if (cmd.win_issue) begin
        i  <= i + AW'(1);
        rp <= (rp == AW'(MAX_FFT - 1)) ? '0 : rp + AW'(1);
      end
      if (cmd.dft_begin) begin
        i <= '0;
        t <= '0;
      end else if (cmd.dft_issue) begin
        i <= i + AW'(1);
        t <= (t_sum >= (NW + 1)'(nf)) ? AW'(t_sum - (NW + 1)'(nf)) : AW'(t_sum);
      end
      if (cmd.mel_begin) begin
        k <= '0;
      end else if (cmd.pwr_write || cmd.mel_issue) begin
        k <= k + KW'(1);
      end
      if (cmd.mel_next) begin
        m     <= m + MW'(1);
        fbase <= fbase + FW'(STRIDE);
      end
    end
  end

  assign stat.last_i = (i == AW'(nf - NW'(1)));
  assign stat.last_k = (k == KW'(nbins - BCW'(1)));
  assign stat.last_m = (m == MW'(mf - MCW'(1)));

  // memories
  logic tab_ok, filt_ok;
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [COEF_W-1:0]      win_rd, cos_rd, sin_rd, filt_rd;
  logic [XW-1:0]          x_rd, x_new;
  logic [POW_W-1:0]       pow_rd, pow_wr;
  logic                   x_we;
  logic [AW-1:0]          i1, i2;

  assign tab_ok  = cmd.take && (32'(feed_index) < 32'(MAX_FFT));
  assign filt_ok = cmd.take && (32'(feed_index) < 32'(FDEPTH));

  lmsf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FFT)) u_ring (
    .clk, .we(samp_take), .waddr(ring_pos), .wdata(feed_sample), .raddr(rp), .rdata(ring_rd)
  );
  lmsf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_FFT)) u_window (
    .clk, .we(tab_ok && (feed_cmd == CMD_WINDOW)), .waddr(AW'(feed_index)),
    .wdata(feed_coef), .raddr(i), .rdata(win_rd)
  );
  lmsf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_FFT)) u_cosine (
    .clk, .we(tab_ok && (feed_cmd == CMD_COSINE)), .waddr(AW'(feed_index)),
    .wdata(feed_coef), .raddr(t), .rdata(cos_rd)
  );
  lmsf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_FFT)) u_sine (
    .clk, .we(tab_ok && (feed_cmd == CMD_SINE)), .waddr(AW'(feed_index)),
    .wdata(feed_coef), .raddr(t), .rdata(sin_rd)
  );
  lmsf_ram #(.WIDTH(COEF_W), .DEPTH(FDEPTH)) u_filter (
    .clk, .we(filt_ok && (feed_cmd == CMD_FILTER)), .waddr(FW'(feed_index)),
    .wdata(feed_coef), .raddr(fidx), .rdata(filt_rd)
  );
  lmsf_ram #(.WIDTH(XW), .DEPTH(MAX_FFT)) u_xbuf (
    .clk, .we(x_we), .waddr(i2), .wdata(x_new), .raddr(i), .rdata(x_rd)
  );
  lmsf_ram #(.WIDTH(POW_W), .DEPTH(STRIDE)) u_power (
    .clk, .we(cmd.pwr_write), .waddr(k), .wdata(pow_wr), .raddr(k), .rdata(pow_rd)
  );

  // MAC pipeline: stage 1 RAM data, stage 2 products, then accumulate or write
  logic [2:0] s1, s2;   // {window, dft, mel}
  logic signed [XW-1:0]     opa, x_s;
  logic signed [COEF_W-1:0] opb;
  logic [WGT_W-1:0]         wpos;
  logic signed [PW-1:0]     prod_a, prod_s;
  logic [MPW-1:0]           prod_m;

  assign x_s  = $signed(x_rd);
  assign opa  = s1[2] ? $signed({ring_rd[SAMPLE_BITS-1], ring_rd}) : x_s;
  assign opb  = s1[2] ? $signed(win_rd) : $signed(cos_rd);
  assign wpos = filt_rd[COEF_W-1] ? '0 : filt_rd[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= {cmd.win_issue, cmd.dft_issue, cmd.mel_issue};
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    i1     <= i;
    i2     <= i1;
    prod_a <= opa * opb;
    prod_s <= x_s * $signed(sin_rd);
    prod_m <= MPW'(pow_rd) * MPW'(wpos) + MPW'(16384);
  end

  assign stat.pipe_busy = (|s1) || (|s2);

  // rounding of Q15 products, half up
  logic signed [PW:0] ra_sum, ra, rs_sum, rs;
  logic signed [TW-1:0] term_c, term_s;
  assign ra_sum = {prod_a[PW-1], prod_a} + $signed((PW + 1)'(16384));
  assign rs_sum = {prod_s[PW-1], prod_s} + $signed((PW + 1)'(16384));
  assign ra     = ra_sum >>> 15;
  assign rs     = rs_sum >>> 15;
  assign term_c = ra[TW-1:0];
  assign term_s = rs[TW-1:0];
  assign x_new  = ra[XW-1:0];
  assign x_we   = s2[2];

  logic signed [ACW-1:0] re_acc, im_acc;
  logic [POW_W-1:0]      macc;
  logic [POW_W:0]        msum;
  assign msum = {1'b0, macc} + {1'b0, prod_m[MPW-1:15]};

  always_ff @(posedge clk) begin
    if (cmd.dft_begin) begin
      re_acc <= '0;
      im_acc <= '0;
    end else if (s2[1]) begin
      re_acc <= re_acc + ACW'(term_c);
      im_acc <= im_acc + ACW'(term_s);
    end
    if (cmd.mel_begin) begin
      macc <= '0;
    end else if (s2[0]) begin
      macc <= msum[POW_W] ? '1 : msum[POW_W-1:0];
    end
  end

  // clamp to 32 bits, square with one shared multiplier
  logic signed [63:0] re_w, im_w, sq_prod, sq_a, sq_b;
  logic signed [31:0] re_c, im_c, sq_op;

  always_comb begin
    re_w = 64'(re_acc);
    im_w = 64'(im_acc);
    if (re_w > 64'sd2147483647) re_c = 32'sh7FFF_FFFF;
    else if (re_w < -64'sd2147483648) re_c = 32'sh8000_0000;
    else re_c = re_w[31:0];
    if (im_w > 64'sd2147483647) im_c = 32'sh7FFF_FFFF;
    else if (im_w < -64'sd2147483648) im_c = 32'sh8000_0000;
    else im_c = im_w[31:0];
  end

  assign sq_op   = cmd.sq_re ? re_c : im_c;
  assign sq_prod = sq_op * sq_op;
  assign pow_wr  = $unsigned(sq_a) + $unsigned(sq_b);

  always_ff @(posedge clk) begin
    if (cmd.sq_re) sq_a <= sq_prod;
    if (cmd.sq_im) sq_b <= sq_prod;
  end

  // log unit: six-step leading-one search, then scale by ln2
  logic [POW_W-1:0]    norm;
  logic [5:0]          lmsb;
  logic [2:0]          lstep;
  logic                lzero;
  logic signed [7:0]   ldif;
  logic signed [15:0]  l2;
  logic signed [33:0]  lprod;
  logic signed [34:0]  lsum, lsh;

  always_ff @(posedge clk) begin
    if (cmd.log_start) begin
      norm  <= macc;
      lmsb  <= 6'd63;
      lstep <= '0;
      lzero <= (macc == '0);
    end else if (cmd.log_step) begin
      lstep <= lstep + 3'd1;
      case (lstep)
        3'd0: if (norm[63:32] == '0) begin norm <= norm << 32; lmsb <= lmsb - 6'd32; end
        3'd1: if (norm[63:48] == '0) begin norm <= norm << 16; lmsb <= lmsb - 6'd16; end
        3'd2: if (norm[63:56] == '0) begin norm <= norm << 8;  lmsb <= lmsb - 6'd8;  end
        3'd3: if (norm[63:60] == '0) begin norm <= norm << 4;  lmsb <= lmsb - 6'd4;  end
        3'd4: if (norm[63:62] == '0) begin norm <= norm << 2;  lmsb <= lmsb - 6'd2;  end
        3'd5: if (!norm[63])         begin norm <= norm << 1;  lmsb <= lmsb - 6'd1;  end
        default: ;
      endcase
    end
    if (cmd.log_mul) begin
      lprod <= l2 * LN2_Q16;
    end
  end

  assign stat.log_done = (lstep == LOG_STEPS);
  assign ldif = $signed({2'b00, lmsb}) - 8'sd30;
  assign l2   = {ldif, norm[62:55]};
  assign lsum = 35'(lprod) + 35'sd32768;
  assign lsh  = lsum >>> 16;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_log   <= lzero ? LOG_FLOOR : lsh[LOG_W-1:0];
      res_mel   <= MIDX_W'(m);
      res_frame <= frame_cnt;
      res_last  <= stat.last_m;
    end
  end

  assign stat.out_free = !res_valid || res_ready;

endmodule
